>>> rtl/core/pse_pkg.sv
// shared constants, codes and types of the phase step event sequencer
package pse_pkg;

	localparam int PSE_STEPS_DEF  = 16;
	localparam int PSE_EVENTS_DEF = 4;
	localparam int RESULT_CAP     = 64;

	localparam int FUNC_W  = 2;
	localparam int PHASE_W = 17;
	localparam int STEP_W  = 4;
	localparam int NOTE_W  = 7;
	localparam int EV_W    = 2 * NOTE_W + 1;

	localparam logic [FUNC_W-1:0] FUNC_PHASE  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

	typedef logic [EV_W-1:0] pse_event_t;

	typedef struct packed {
		logic wr;
		logic clr;
		logic rd;
	} pse_mem_ctl_t;

endpackage

>>> rtl/core/pse_in_if.sv
// command word channel: phase samples, event appends and table clears
interface pse_in_if
	import pse_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [FUNC_W-1:0]         func;
	logic signed [PHASE_W-1:0] phase;
	logic [STEP_W-1:0]         step;
	logic [NOTE_W-1:0]         note;
	logic [NOTE_W-1:0]         velocity;
	logic                      is_on;

	modport source (output valid, func, phase, step, note, velocity, is_on, input ready);
	modport sink (input valid, func, phase, step, note, velocity, is_on, output ready);
endinterface

>>> rtl/core/pse_out_if.sv
// emitted note event word channel
interface pse_out_if
	import pse_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [NOTE_W-1:0] out_note;
	logic [NOTE_W-1:0] out_velocity;
	logic              out_is_on;
	logic [STEP_W-1:0] out_step;
	logic              last;

	modport source (output valid, out_note, out_velocity, out_is_on, out_step, last,
		input ready);
	modport sink (input valid, out_note, out_velocity, out_is_on, out_step, last,
		output ready);
endinterface

>>> rtl/core/pse_store.sv
// per-step slot counters and event memory
module pse_store
	import pse_pkg::*;
#(
	parameter int STORE_STEPS     = PSE_STEPS_DEF,
	parameter int EVENTS_PER_STEP = PSE_EVENTS_DEF,
	localparam int IW = $clog2(STORE_STEPS),
	localparam int CW = $clog2(EVENTS_PER_STEP + 1)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  pse_mem_ctl_t ctl,
	input  logic [IW-1:0] idx,
	input  logic [CW-1:0] slot,
	output logic [CW-1:0] cnt,
	input  pse_event_t   wr_data,
	output pse_event_t   rd_data
);
	localparam int DEPTH = STORE_STEPS * EVENTS_PER_STEP;
	localparam int AW    = $clog2(DEPTH);

	logic [CW-1:0] cnt_q [STORE_STEPS];
	pse_event_t    mem [DEPTH];
	logic [AW-1:0] base;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	assign cnt     = cnt_q[idx];
	assign base    = AW'(idx) * AW'(EVENTS_PER_STEP);
	assign wr_addr = base + AW'(cnt_q[idx]);
	assign rd_addr = base + AW'(slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_STEPS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (ctl.clr) begin
			for (int i = 0; i < STORE_STEPS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (ctl.wr) begin
			cnt_q[idx] <= cnt_q[idx] + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

>>> rtl/core/pse_scan.sv
// phase to step mapping, step scan sequencer and output word register
module pse_scan
	import pse_pkg::*;
#(
	parameter int PATTERN_STEPS   = PSE_STEPS_DEF,
	parameter int EVENTS_PER_STEP = PSE_EVENTS_DEF,
	parameter int STORE_STEPS     = PSE_STEPS_DEF,
	localparam int IW = $clog2(STORE_STEPS),
	localparam int CW = $clog2(EVENTS_PER_STEP + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	pse_in_if.sink        cmd,
	pse_out_if.source     evt,
	output pse_mem_ctl_t  ctl,
	output logic [IW-1:0] idx,
	output logic [CW-1:0] slot,
	input  logic [CW-1:0] cnt,
	output pse_event_t    wr_data,
	input  pse_event_t    rd_data
);
	localparam int PSW = $clog2(PATTERN_STEPS + 1);
	localparam int SW  = PSW + 1;
	localparam int PW  = PHASE_W + SW;
	localparam int NW  = $clog2(RESULT_CAP + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PLAN  = 3'd1;
	localparam logic [2:0] ST_STEP  = 3'd2;
	localparam logic [2:0] ST_DATA  = 3'd3;
	localparam logic [2:0] ST_FLUSH = 3'd4;

	logic [2:0]           state_q;
	logic signed [SW-1:0] right_q;
	logic                 first_q;
	logic [PSW-1:0]       pos_q;
	logic [PSW-1:0]       cur_q;
	logic [PSW-1:0]       end_q;
	logic                 wrap_q;
	logic [CW-1:0]        slot_q;
	logic [NW-1:0]        sent_q;
	logic                 pend_v_q;
	pse_event_t           pend_ev_q;
	logic [STEP_W-1:0]    pend_step_q;
	logic                 out_v_q;
	pse_event_t           out_ev_q;
	logic [STEP_W-1:0]    out_step_q;
	logic                 out_last_q;

	logic signed [PW-1:0]   prod;
	logic                   accept;
	logic                   out_free;
	logic                   in_range;
	logic                   have_ev;
	logic                   append_ok;
	logic                   out_load;
	logic                   pend_take;
	logic signed [SW-1:0]   right_nxt;
	logic [PSW-1:0]         rpos;
	logic [PSW:0]           rpos_inc;
	logic [PSW+STEP_W-1:0]  cur_ext;

	assign prod      = PW'(cmd.phase) * $signed(PW'(PATTERN_STEPS));
	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign out_free  = !out_v_q || evt.ready;

	assign right_nxt = right_q + SW'(1);
	assign rpos      = right_q[PSW-1:0];
	assign rpos_inc  = {1'b0, rpos} + (PSW + 1)'(1);
	assign cur_ext   = {{STEP_W{1'b0}}, cur_q};

	assign idx  = (state_q == ST_IDLE) ? cmd.step[IW-1:0] : cur_q[IW-1:0];
	assign slot = slot_q;

	assign in_range  = cur_q < PSW'(STORE_STEPS);
	assign have_ev   = in_range && (slot_q < cnt) && (sent_q < NW'(RESULT_CAP));
	assign append_ok = ({1'b0, cmd.step} < (STEP_W + 1)'(STORE_STEPS)) &&
		(cnt < CW'(EVENTS_PER_STEP));

	assign ctl.wr  = accept && (cmd.func == FUNC_APPEND) && append_ok;
	assign ctl.clr = accept && (cmd.func == FUNC_CLEAR);
	assign ctl.rd  = (state_q == ST_STEP) && have_ev;
	assign wr_data = {cmd.note, cmd.velocity, cmd.is_on};

	assign out_load  = out_free && pend_v_q &&
		((state_q == ST_DATA) || (state_q == ST_FLUSH));
	assign pend_take = (state_q == ST_DATA) && (!pend_v_q || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			first_q  <= 1'b1;
			pos_q    <= '0;
			cur_q    <= '0;
			end_q    <= '0;
			wrap_q   <= 1'b0;
			slot_q   <= '0;
			sent_q   <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (evt.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (cmd.func == FUNC_PHASE)) begin
						state_q <= ST_PLAN;
					end
				end
				ST_PLAN: begin
					first_q <= right_nxt[SW-1];
					pos_q   <= right_nxt[PSW-1:0];
					slot_q  <= '0;
					sent_q  <= '0;
					end_q   <= rpos;
					if (right_q[SW-1]) begin
						state_q <= ST_IDLE;
					end else if (first_q) begin
						cur_q   <= rpos;
						wrap_q  <= 1'b0;
						state_q <= ST_STEP;
					end else if ({1'b0, pos_q} > rpos_inc) begin
						cur_q   <= pos_q;
						wrap_q  <= 1'b1;
						state_q <= ST_STEP;
					end else if ({1'b0, pos_q} == rpos_inc) begin
						state_q <= ST_IDLE;
					end else begin
						cur_q   <= pos_q;
						wrap_q  <= 1'b0;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (have_ev) begin
						state_q <= ST_DATA;
					end else begin
						slot_q <= '0;
						if (wrap_q && (cur_q >= PSW'(PATTERN_STEPS - 1))) begin
							cur_q  <= '0;
							wrap_q <= 1'b0;
						end else if (!wrap_q && (cur_q == end_q)) begin
							state_q <= ST_FLUSH;
						end else begin
							cur_q <= cur_q + PSW'(1);
						end
					end
				end
				ST_DATA: begin
					if (pend_take) begin
						pend_v_q <= 1'b1;
						slot_q   <= slot_q + CW'(1);
						sent_q   <= sent_q + NW'(1);
						state_q  <= ST_STEP;
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd.func == FUNC_PHASE)) begin
			right_q <= $signed(prod[SW+15:16]);
		end
		if (out_load) begin
			out_ev_q   <= pend_ev_q;
			out_step_q <= pend_step_q;
			out_last_q <= (state_q == ST_FLUSH);
		end
		if (pend_take) begin
			pend_ev_q   <= rd_data;
			pend_step_q <= cur_ext[STEP_W-1:0];
		end
	end

	assign evt.valid        = out_v_q;
	assign evt.out_note     = out_ev_q[EV_W-1:NOTE_W+1];
	assign evt.out_velocity = out_ev_q[NOTE_W:1];
	assign evt.out_is_on    = out_ev_q[0];
	assign evt.out_step     = out_step_q;
	assign evt.last         = out_last_q;

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_v_q)
		else $error("pending word left behind in idle");

	a_read_then_data: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd |=> (state_q == ST_DATA))
		else $error("memory read not followed by data state");

	a_result_cap: assert property (@(posedge clk) disable iff (!arst_n)
		sent_q <= NW'(RESULT_CAP))
		else $error("result count beyond cap");

	a_negative_phase: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_PLAN) && right_q[SW-1]) |=> (state_q == ST_IDLE))
		else $error("negative phase started a scan");
endmodule

>>> rtl/core/phase_step_event_sequencer.sv
// phase step event sequencer: append and clear words are taken in idle without leaving it, ready stays high in idle
// a phase sample holds ready low for a planning state, a step state per step position scanned,
// a step and a data state per event word and a closing flush state, longer while the output is stalled
// a sample that scans nothing passes only through the planning state
// each word of a sample waits in a pending register until a later data or flush state moves it to the output
// reset clears all slot counts and the scan position; the event memory is not cleared
module phase_step_event_sequencer
	import pse_pkg::*;
#(
	parameter int PATTERN_STEPS   = PSE_STEPS_DEF,
	parameter int EVENTS_PER_STEP = PSE_EVENTS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	pse_in_if.sink    cmd,
	pse_out_if.source evt
);
	localparam int STORE_STEPS = (PATTERN_STEPS < (2 ** STEP_W)) ? PATTERN_STEPS : (2 ** STEP_W);
	localparam int IW = $clog2(STORE_STEPS);
	localparam int CW = $clog2(EVENTS_PER_STEP + 1);

	pse_mem_ctl_t  ctl;
	logic [IW-1:0] idx;
	logic [CW-1:0] slot;
	logic [CW-1:0] cnt;
	pse_event_t    wr_data;
	pse_event_t    rd_data;

	pse_scan #(
		.PATTERN_STEPS   (PATTERN_STEPS),
		.EVENTS_PER_STEP (EVENTS_PER_STEP),
		.STORE_STEPS     (STORE_STEPS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.evt     (evt),
		.ctl     (ctl),
		.idx     (idx),
		.slot    (slot),
		.cnt     (cnt),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	pse_store #(
		.STORE_STEPS     (STORE_STEPS),
		.EVENTS_PER_STEP (EVENTS_PER_STEP)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.idx     (idx),
		.slot    (slot),
		.cnt     (cnt),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);
endmodule
